// ===== hdl/rtba_pkg.sv =====
package rtba_pkg;

  localparam int KIND_W = 2;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] KIND_FREE     = 2'd0;
  localparam logic [1:0] KIND_RESERVED = 2'd1;
  localparam logic [1:0] KIND_OWNED    = 2'd2;
  localparam logic [1:0] KIND_UNMAPPED = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ZERO     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_DONE
  } fsm_t;

  // rewrite pass: INS opens a hole, DEL closes up to two slots
  typedef enum logic {
    M_DEL,
    M_INS
  } mode_t;

endpackage

// ===== hdl/rtba_slot.sv =====
module rtba_slot
  import rtba_pkg::*;
#(
  parameter int BLOCK_BITS = 40
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [BLOCK_BITS-1:0] in_base,
  input  logic [BLOCK_BITS-1:0] in_len,
  input  logic [KIND_W-1:0]     in_kind,
  output logic [BLOCK_BITS-1:0] q_base,
  output logic [BLOCK_BITS-1:0] q_len,
  output logic [KIND_W-1:0]     q_kind
);

  logic [BLOCK_BITS-1:0] base_r;
  logic [BLOCK_BITS-1:0] len_r;
  logic [KIND_W-1:0]     kind_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      base_r <= in_base;
      len_r  <= in_len;
      kind_r <= in_kind;
    end
  end

  assign q_base = base_r;
  assign q_len  = len_r;
  assign q_kind = kind_r;

endmodule

// ===== hdl/region_table_block_allocator.sv =====
// A new item is accepted only in idle, after the result of the last one is out.
// busy stays high from acceptance through the result strobe.
// The table is a ring of slots rotated once to search and once to rewrite it.
// Reset (rst_n low, synchronous) empties the table, drops the roving cursor and
// sets first fit. The receiver cannot stall; each result is shown for one cycle.
module region_table_block_allocator
  import rtba_pkg::*;
#(
  parameter int REGION_ENTRIES = 64,
  parameter int BLOCK_BITS     = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic                  in_first_region,
  input  logic [BLOCK_BITS-1:0] in_region_base,
  input  logic [BLOCK_BITS-1:0] in_block_count,
  input  logic [1:0]            in_region_kind,
  output logic                  out_valid,
  output logic [2:0]            out_status,
  output logic [BLOCK_BITS-1:0] out_result_base,
  output logic [1:0]            out_result_type,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_wdata
);

  localparam int N  = REGION_ENTRIES;
  localparam int BB = BLOCK_BITS;
  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] LAST = CW'(N - 1);
  localparam logic [CW-1:0] FULL = CW'(N);

  fsm_t state_r, state_nxt;

  logic [BB-1:0]     s_base [N];
  logic [BB-1:0]     s_len  [N];
  logic [KIND_W-1:0] s_kind [N];
  logic [BB-1:0]     t_base, t_len;
  logic [KIND_W-1:0] t_kind;
  logic              shift;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_slot
      if (g == N - 1) begin : g_tail
        rtba_slot #(.BLOCK_BITS(BB)) u_slot (
          .clk(clk), .shift(shift),
          .in_base(t_base), .in_len(t_len), .in_kind(t_kind),
          .q_base(s_base[g]), .q_len(s_len[g]), .q_kind(s_kind[g])
        );
      end else begin : g_body
        rtba_slot #(.BLOCK_BITS(BB)) u_slot (
          .clk(clk), .shift(shift),
          .in_base(s_base[g+1]), .in_len(s_len[g+1]), .in_kind(s_kind[g+1]),
          .q_base(s_base[g]), .q_len(s_len[g]), .q_kind(s_kind[g])
        );
      end
    end
  endgenerate

  // control state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic          cv_r, cv_nxt;
  logic [1:0]    pol_r, pol_nxt;
  logic [CW-1:0] k_r, k_nxt;

  // item word
  logic [1:0]        op_r;
  logic [BB-1:0]     b_r, n_r;
  logic [KIND_W-1:0] kd_r;

  // scan results
  logic              fnd_r, fnd_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic [BB-1:0]     fb_r, fb_nxt, fl_r, fl_nxt;
  logic              afnd_r, afnd_nxt;
  logic [CW-1:0]     ap_r, ap_nxt;
  logic [BB-1:0]     ab_r, ab_nxt, al_r, al_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [1:0]        rt_r, rt_nxt;
  logic [BB-1:0]     rb_r, rb_nxt;

  // rewrite plan
  mode_t             mode_r, mode_nxt;
  logic              split_r, split_nxt;
  logic              men_r, men_nxt;
  logic [CW-1:0]     m_r, m_nxt, q_r, q_nxt;
  logic [1:0]        r_r, r_nxt;
  logic [BB-1:0]     ml_r, ml_nxt;
  logic [KIND_W-1:0] mt_r, mt_nxt;
  logic [BB-1:0]     nb_r, nb_nxt, nl_r, nl_nxt;
  logic [KIND_W-1:0] nk_r, nk_nxt;

  // previous head word
  logic [BB-1:0]     h_base_r, h_len_r;
  logic [KIND_W-1:0] h_kind_r;

  logic accept;
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_SCAN;
      S_SCAN:   if (k_r == LAST) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_WRITE;
      S_WRITE:  if (k_r == LAST) state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    shift     = (state_r == S_SCAN) || (state_r == S_WRITE);
    cfg_ready = 1'b1;
  end

  assign out_status      = st_r;
  assign out_result_base = rb_r;
  assign out_result_type = rt_r;

  logic              hv, pv, nv;
  logic              fit, cand_start;
  logic [CW-1:0]     nf_start;
  logic [BB:0]       cov_end;
  logic              pf, nf;
  logic              ch_fnd;
  logic [CW-1:0]     ch_p;
  logic [BB-1:0]     ch_b, ch_l;
  logic [CW:0]       q_end;

  always_comb begin
    cnt_nxt = cnt_r; cur_nxt = cur_r; cv_nxt = cv_r; pol_nxt = pol_r; k_nxt = k_r;
    fnd_nxt = fnd_r; p_nxt = p_r; fb_nxt = fb_r; fl_nxt = fl_r;
    afnd_nxt = afnd_r; ap_nxt = ap_r; ab_nxt = ab_r; al_nxt = al_r;
    st_nxt = st_r; rt_nxt = rt_r; rb_nxt = rb_r;
    mode_nxt = mode_r; split_nxt = split_r; men_nxt = men_r;
    m_nxt = m_r; q_nxt = q_r; r_nxt = r_r; ml_nxt = ml_r; mt_nxt = mt_r;
    nb_nxt = nb_r; nl_nxt = nl_r; nk_nxt = nk_r;
    t_base = s_base[0]; t_len = s_len[0]; t_kind = s_kind[0];

    hv  = (k_r < cnt_r);
    pv  = (k_r != '0);
    nv  = ((k_r + CW'(1)) < cnt_r);
    fit = hv && (s_kind[0] == KIND_FREE) && (s_len[0] >= n_r);
    nf_start   = (cv_r && (cur_r < cnt_r)) ? cur_r : '0;
    cand_start = (pol_r != POL_NEXT) || (k_r >= nf_start);
    cov_end    = {1'b0, s_base[0]} + {1'b0, s_len[0]};
    pf = pv && (h_kind_r == KIND_FREE);
    nf = nv && (s_kind[1] == KIND_FREE);
    ch_fnd = fnd_r || (pol_r == POL_NEXT && afnd_r);
    ch_p   = fnd_r ? p_r : ap_r;
    ch_b   = fnd_r ? fb_r : ab_r;
    ch_l   = fnd_r ? fl_r : al_r;
    q_end  = {1'b0, q_r} + {{(CW-1){1'b0}}, r_r};

    if (cfg_valid && cfg_ready) pol_nxt = cfg_wdata;

    if (shift) k_nxt = (k_r == LAST) ? '0 : k_r + CW'(1);

    case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        fnd_nxt = 1'b0; afnd_nxt = 1'b0;
        st_nxt = ST_OK; rb_nxt = '0;
        rt_nxt = (in_opcode == OP_QUERY) ? KIND_UNMAPPED : KIND_FREE;
        mode_nxt = M_DEL; split_nxt = 1'b0; men_nxt = 1'b0;
        r_nxt = '0; m_nxt = '0; q_nxt = '0;
        if (accept && in_opcode == OP_ADD && in_first_region) begin
          cnt_nxt = '0;
          cv_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        case (op_r)
          OP_ADD: begin
            if (hv && !fnd_nxt && !((b_r > s_base[0]) ||
                (b_r == s_base[0] && n_r > s_len[0]))) begin
              fnd_nxt = 1'b1; p_nxt = k_r;
            end
          end
          OP_ALLOC: begin
            if (fit && !afnd_r) begin
              afnd_nxt = 1'b1; ap_nxt = k_r; ab_nxt = s_base[0]; al_nxt = s_len[0];
            end
            if (fit && cand_start && (!fnd_r ||
                (pol_r == POL_BEST && s_len[0] < fl_r) ||
                (pol_r == POL_WORST && s_len[0] > fl_r))) begin
              fnd_nxt = 1'b1; p_nxt = k_r; fb_nxt = s_base[0]; fl_nxt = s_len[0];
            end
          end
          OP_FREE: begin
            if (hv && !fnd_r && !(b_r > s_base[0])) begin
              fnd_nxt = 1'b1;
              if (s_base[0] != b_r || s_kind[0] == KIND_FREE) begin
                st_nxt = ST_NOTFOUND;
              end else begin
                men_nxt = 1'b1;
                mt_nxt  = KIND_FREE;
                if (pf && nf) begin
                  m_nxt = k_r - CW'(1); q_nxt = k_r; r_nxt = 2'd2;
                  ml_nxt = h_len_r + s_len[0] + s_len[1];
                end else if (pf) begin
                  m_nxt = k_r - CW'(1); q_nxt = k_r; r_nxt = 2'd1;
                  ml_nxt = h_len_r + s_len[0];
                end else if (nf) begin
                  m_nxt = k_r; q_nxt = k_r + CW'(1); r_nxt = 2'd1;
                  ml_nxt = s_len[0] + s_len[1];
                end else begin
                  m_nxt = k_r; q_nxt = k_r; r_nxt = 2'd0;
                  ml_nxt = s_len[0];
                end
              end
            end
          end
          default: begin
            if (hv && !fnd_r && (b_r >= s_base[0]) && ({1'b0, b_r} < cov_end)) begin
              fnd_nxt = 1'b1; rt_nxt = s_kind[0];
            end
          end
        endcase
      end
      S_DECIDE: begin
        case (op_r)
          OP_ADD: begin
            if (cnt_r == FULL) begin
              st_nxt = ST_FULL;
            end else begin
              mode_nxt = M_INS;
              p_nxt = fnd_r ? p_r : cnt_r;
              nb_nxt = b_r; nl_nxt = n_r;
              nk_nxt = (kd_r == KIND_UNMAPPED) ? KIND_RESERVED : kd_r;
              cnt_nxt = cnt_r + CW'(1);
              if (cv_r && (p_nxt <= cur_r)) cur_nxt = cur_r + CW'(1);
            end
          end
          OP_ALLOC: begin
            if (n_r == '0) begin
              st_nxt = ST_ZERO;
            end else if (!ch_fnd) begin
              st_nxt = ST_NO_FIT;
            end else if (ch_l == n_r) begin
              rb_nxt = ch_b;
              men_nxt = 1'b1; m_nxt = ch_p; q_nxt = ch_p; r_nxt = '0;
              ml_nxt = ch_l; mt_nxt = KIND_RESERVED;
              if (pol_r == POL_NEXT) begin
                cur_nxt = ch_p; cv_nxt = 1'b1;
              end
            end else if (cnt_r == FULL) begin
              st_nxt = ST_FULL;
            end else begin
              rb_nxt = ch_b;
              mode_nxt = M_INS; split_nxt = 1'b1;
              p_nxt = ch_p; nb_nxt = ch_b; nl_nxt = n_r; nk_nxt = KIND_RESERVED;
              cnt_nxt = cnt_r + CW'(1);
              if (pol_r == POL_NEXT) begin
                cur_nxt = ch_p + CW'(1); cv_nxt = 1'b1;
              end else if (cv_r && ch_p <= cur_r) begin
                cur_nxt = cur_r + CW'(1);
              end
            end
          end
          OP_FREE: begin
            if (!fnd_r) st_nxt = ST_NOTFOUND;
            cnt_nxt = cnt_r - CW'(r_r);
            if (cv_r && r_r != '0) begin
              if ({1'b0, cur_r} >= q_end) cur_nxt = cur_r - CW'(r_r);
              else if (cur_r >= q_r)      cv_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      S_WRITE: begin
        if (mode_r == M_INS) begin
          if (k_r == p_r) begin
            t_base = nb_r; t_len = nl_r; t_kind = nk_r;
          end else if (k_r > p_r) begin
            t_base = h_base_r; t_len = h_len_r; t_kind = h_kind_r;
            // remainder of a split: head cut away
            if (split_r && k_r == p_r + CW'(1)) begin
              t_base = h_base_r + n_r;
              t_len  = h_len_r - n_r;
            end
          end
        end else begin
          if (k_r >= q_r && r_r == 2'd1) begin
            t_base = s_base[1]; t_len = s_len[1]; t_kind = s_kind[1];
          end else if (k_r >= q_r && r_r == 2'd2) begin
            t_base = s_base[2]; t_len = s_len[2]; t_kind = s_kind[2];
          end
          if (men_r && k_r == m_r) begin
            t_len = ml_r; t_kind = mt_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cur_r   <= '0;
      cv_r    <= 1'b0;
      pol_r   <= POL_FIRST;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      cv_r    <= cv_nxt;
      pol_r   <= pol_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      b_r  <= in_region_base;
      n_r  <= in_block_count;
      kd_r <= in_region_kind;
    end
    if (shift) begin
      h_base_r <= s_base[0];
      h_len_r  <= s_len[0];
      h_kind_r <= s_kind[0];
    end
    fnd_r <= fnd_nxt; p_r <= p_nxt; fb_r <= fb_nxt; fl_r <= fl_nxt;
    afnd_r <= afnd_nxt; ap_r <= ap_nxt; ab_r <= ab_nxt; al_r <= al_nxt;
    st_r <= st_nxt; rt_r <= rt_nxt; rb_r <= rb_nxt;
    mode_r <= mode_nxt; split_r <= split_nxt; men_r <= men_nxt;
    m_r <= m_nxt; q_r <= q_nxt; r_r <= r_nxt; ml_r <= ml_nxt; mt_r <= mt_nxt;
    nb_r <= nb_nxt; nl_r <= nl_nxt; nk_r <= nk_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL) else $error("entry count above table size");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cv_r) |-> (cur_r < cnt_r))
    else $error("roving cursor outside table");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accepted word not in work");

endmodule

// ===== dv/tb_region_table_block_allocator.sv =====
module tb_region_table_block_allocator;
  import rtba_pkg::*;

  localparam int ENTRIES = 64;
  localparam int BB = 40;
  localparam int LATENCY = 2 * ENTRIES + 3;
  localparam longint LIMIT = 4000000;

  typedef logic [BB-1:0] blk_t;

  typedef struct packed {
    logic [2:0] status;
    blk_t       base;
    logic [1:0] rtype;
  } resp_t;

  typedef struct {
    logic [1:0] op;
    logic       first;
    blk_t       base;
    blk_t       count;
    logic [1:0] kind;
    logic       has_exp;
    resp_t      exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = OP_ADD;
  logic in_first_region = 1'b0;
  blk_t in_region_base = '0;
  blk_t in_block_count = '0;
  logic [1:0] in_region_kind = KIND_FREE;
  logic out_valid;
  logic [2:0] out_status;
  blk_t out_result_base;
  logic [1:0] out_result_type;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_wdata = POL_FIRST;

  region_table_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_first_region(in_first_region),
    .in_region_base(in_region_base), .in_block_count(in_block_count),
    .in_region_kind(in_region_kind), .out_valid(out_valid),
    .out_status(out_status), .out_result_base(out_result_base),
    .out_result_type(out_result_type), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  blk_t       tbl_base [ENTRIES];
  blk_t       tbl_len [ENTRIES];
  logic [1:0] tbl_kind [ENTRIES];
  int         tbl_cnt;
  int         rove;
  bit         rove_ok;
  logic [1:0] policy;

  resp_t pending_words[$];
  int    errors = 0;
  int    words_seen = 0;
  longint cycles = 0;
  int    send_idle = 25;
  int    tally[4];

  function automatic void tbl_insert(int pos, blk_t b, blk_t len, logic [1:0] k);
    for (int i = tbl_cnt; i > pos; i--) begin
      tbl_base[i] = tbl_base[i-1];
      tbl_len[i] = tbl_len[i-1];
      tbl_kind[i] = tbl_kind[i-1];
    end
    tbl_base[pos] = b;
    tbl_len[pos] = len;
    tbl_kind[pos] = k;
    tbl_cnt++;
    if (rove_ok && pos <= rove) rove++;
  endfunction

  function automatic void tbl_remove(int pos);
    for (int i = pos; i + 1 < tbl_cnt; i++) begin
      tbl_base[i] = tbl_base[i+1];
      tbl_len[i] = tbl_len[i+1];
      tbl_kind[i] = tbl_kind[i+1];
    end
    tbl_cnt--;
    if (rove_ok) begin
      if (pos == rove) rove_ok = 1'b0;
      else if (pos < rove) rove--;
    end
  endfunction

  function automatic int pick_region(blk_t n);
    int found;
    int st;
    int k;
    found = tbl_cnt;
    if (policy == POL_NEXT) begin
      st = (rove_ok && rove < tbl_cnt) ? rove : 0;
      for (int i = 0; i < tbl_cnt; i++) begin
        k = st + i;
        if (k >= tbl_cnt) k -= tbl_cnt;
        if (tbl_kind[k] == KIND_FREE && tbl_len[k] >= n) return k;
      end
      return tbl_cnt;
    end
    for (int i = 0; i < tbl_cnt; i++) begin
      if (tbl_kind[i] != KIND_FREE || tbl_len[i] < n) continue;
      if (policy == POL_FIRST) return i;
      if (found == tbl_cnt
          || (policy == POL_BEST && tbl_len[i] < tbl_len[found])
          || (policy == POL_WORST && tbl_len[i] > tbl_len[found]))
        found = i;
    end
    return found;
  endfunction

  function automatic resp_t predict_region_op(logic [1:0] op, logic first, blk_t b,
                                              blk_t n, logic [1:0] kind);
    resp_t r;
    int i;
    int f;
    logic [1:0] k;
    logic [BB:0] sum;
    r = '0;
    case (op)
      OP_ADD: begin
        k = (kind == KIND_UNMAPPED) ? KIND_RESERVED : kind;
        if (first) begin
          tbl_cnt = 0;
          rove_ok = 1'b0;
        end
        if (tbl_cnt >= ENTRIES) r.status = ST_FULL;
        else begin
          i = 0;
          while (i < tbl_cnt && (b > tbl_base[i] || (b == tbl_base[i] && n > tbl_len[i])))
            i++;
          tbl_insert(i, b, n, k);
        end
      end
      OP_ALLOC: begin
        if (n == 0) r.status = ST_ZERO;
        else begin
          f = pick_region(n);
          if (f >= tbl_cnt) r.status = ST_NO_FIT;
          else if (tbl_len[f] == n) begin
            tbl_kind[f] = KIND_RESERVED;
            r.base = tbl_base[f];
            if (policy == POL_NEXT) begin
              rove = f;
              rove_ok = 1'b1;
            end
          end else if (tbl_cnt >= ENTRIES) r.status = ST_FULL;
          else begin
            r.base = tbl_base[f];
            if (policy == POL_NEXT) begin
              rove = f;
              rove_ok = 1'b1;
            end
            tbl_insert(f, r.base, n, KIND_RESERVED);
            f++;
            tbl_base[f] = tbl_base[f] + n;
            tbl_len[f] = tbl_len[f] - n;
          end
        end
      end
      OP_FREE: begin
        i = 0;
        while (i < tbl_cnt && b > tbl_base[i]) i++;
        if (i >= tbl_cnt || tbl_base[i] != b || tbl_kind[i] == KIND_FREE)
          r.status = ST_NOTFOUND;
        else begin
          tbl_kind[i] = KIND_FREE;
          if (i > 0 && tbl_kind[i-1] == KIND_FREE) begin
            tbl_len[i-1] = tbl_len[i-1] + tbl_len[i];
            tbl_remove(i);
            i--;
          end
          if (i + 1 < tbl_cnt && tbl_kind[i+1] == KIND_FREE) begin
            tbl_len[i] = tbl_len[i] + tbl_len[i+1];
            tbl_remove(i + 1);
          end
        end
      end
      default: begin
        r.rtype = KIND_UNMAPPED;
        for (i = 0; i < tbl_cnt; i++) begin
          // end of region is not wrapped
          sum = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
          if (b >= tbl_base[i] && {1'b0, b} < sum) begin
            r.rtype = tbl_kind[i];
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    resp_t got;
    resp_t want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_result_base, out_result_type};
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status);
          errors++;
        end
        if (got.base !== want.base) begin
          $error("result_base exp %0h got %0h", want.base, got.base);
          errors++;
        end
        if (got.rtype !== want.rtype) begin
          $error("result_type exp %0d got %0d", want.rtype, got.rtype);
          errors++;
        end
      end
    end
  end

  task automatic issue(logic [1:0] op, logic first, blk_t b, blk_t n, logic [1:0] kind,
                       bit has_exp, resp_t exp);
    resp_t p;
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_opcode <= op;
    in_first_region <= first;
    in_region_base <= b;
    in_block_count <= n;
    in_region_kind <= kind;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_region_op(op, first, b, n, kind);
    if (has_exp && p !== exp) begin
      $error("directed row: table says %p, predictor %p", exp, p);
      errors++;
    end
    pending_words.push_back(p);
    tally[op]++;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    cfg_wdata <= p;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    policy = p;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic blk_t rnd_blk();
    return {$urandom(), $urandom()};
  endfunction

  localparam blk_t BMAX = '1;
  row_t directed[] = '{
    '{OP_ALLOC, 0, 0, 5, 0, 1, '{ST_NO_FIT, '0, 2'd0}},
    '{OP_FREE, 0, 0, 0, 0, 1, '{ST_NOTFOUND, '0, 2'd0}},
    '{OP_QUERY, 0, 7, 0, 0, 1, '{ST_OK, '0, KIND_UNMAPPED}},
    '{OP_ALLOC, 0, 0, 0, 0, 1, '{ST_ZERO, '0, 2'd0}},
    '{OP_ADD, 1, 100, 50, KIND_FREE, 1, '{ST_OK, '0, 2'd0}},
    '{OP_ADD, 0, 200, 0, KIND_FREE, 0, '0},
    '{OP_ADD, 0, 300, 20, KIND_UNMAPPED, 0, '0},
    '{OP_ADD, 0, BMAX, BMAX, KIND_OWNED, 0, '0},
    '{OP_QUERY, 0, 310, 0, 0, 1, '{ST_OK, '0, KIND_RESERVED}},
    '{OP_QUERY, 0, 200, 0, 0, 1, '{ST_OK, '0, KIND_UNMAPPED}},
    '{OP_ALLOC, 0, 0, 10, 0, 1, '{ST_OK, 40'd100, 2'd0}},
    '{OP_ALLOC, 0, 0, 40, 0, 1, '{ST_OK, 40'd110, 2'd0}},
    '{OP_ALLOC, 0, 0, BMAX, 0, 1, '{ST_NO_FIT, '0, 2'd0}},
    '{OP_FREE, 0, 100, 0, 0, 0, '0},
    '{OP_FREE, 0, 110, 0, 0, 0, '0},
    '{OP_FREE, 0, 110, 0, 0, 1, '{ST_NOTFOUND, '0, 2'd0}},
    '{OP_FREE, 0, 300, 0, 0, 0, '0},
    '{OP_FREE, 0, BMAX, 0, 0, 0, '0},
    '{OP_ALLOC, 0, 0, BMAX, 0, 0, '0},
    '{OP_QUERY, 0, BMAX, 0, 0, 0, '0},
    '{OP_ADD, 0, 0, BMAX, KIND_OWNED, 0, '0},
    '{OP_QUERY, 0, 5, 0, 0, 0, '0}
  };

  task automatic fill_table();
    for (int i = 0; i < ENTRIES + 2; i++)
      issue(OP_ADD, i == 0, blk_t'(i * 16), 40'd16, i[0] ? KIND_OWNED : KIND_FREE, 0, '0);
    issue(OP_ALLOC, 0, 0, 40'd3, 0, 0, '0);
    issue(OP_ALLOC, 0, 0, 40'd16, 0, 0, '0);
  endtask

  // mostly well-formed traffic on a small block space so frees hit real bases
  task automatic random_phase(int items, logic [1:0] pol);
    blk_t known[$];
    int r;
    blk_t b;
    blk_t n;
    set_policy(pol);
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (i == 0 || r < 4) begin
        known.delete();
        b = $urandom_range(255);
        n = $urandom_range(4000, 1);
        known.push_back(b);
        issue(OP_ADD, 1, b, n, KIND_FREE, 0, '0);
      end else if (r < 18) begin
        b = (r < 6) ? rnd_blk() : blk_t'($urandom_range(8000));
        n = (r < 7) ? rnd_blk() : blk_t'($urandom_range(600));
        known.push_back(b);
        issue(OP_ADD, $urandom_range(99) == 0, b, n, $urandom_range(3), 0, '0);
      end else if (r < 55) begin
        n = (r < 20) ? rnd_blk() : blk_t'($urandom_range(300));
        issue(OP_ALLOC, $urandom_range(1), rnd_blk(), n, $urandom_range(3), 0, '0);
      end else if (r < 80) begin
        if (tbl_cnt > 0 && r < 77) b = tbl_base[$urandom_range(tbl_cnt - 1)];
        else b = (known.size() > 0) ? known[$urandom_range(known.size() - 1)] : rnd_blk();
        issue(OP_FREE, $urandom_range(1), b, rnd_blk(), $urandom_range(3), 0, '0);
      end else begin
        b = (r < 83) ? rnd_blk() : blk_t'($urandom_range(9000));
        issue(OP_QUERY, $urandom_range(1), b, rnd_blk(), $urandom_range(3), 0, '0);
      end
    end
    drain();
  endtask

  initial begin
    tbl_cnt = 0;
    rove = 0;
    rove_ok = 1'b0;
    policy = POL_FIRST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      issue(directed[i].op, directed[i].first, directed[i].base, directed[i].count,
            directed[i].kind, directed[i].has_exp, directed[i].exp);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_policy(p[1:0]);
      fill_table();
      drain();
    end

    send_idle = 25;
    random_phase(260, POL_FIRST);
    random_phase(260, POL_NEXT);
    send_idle = 62;
    random_phase(260, POL_BEST);
    random_phase(260, POL_WORST);
    send_idle = 0;
    random_phase(260, POL_NEXT);
    random_phase(260, POL_FIRST);

    $display("Covered all four fit policies; items add %0d alloc %0d free %0d query %0d",
             tally[0], tally[1], tally[2], tally[3]);
    $display("Result words checked: %0d, mismatches: %0d", words_seen, errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
